// ----- rtl/core/pai_pkg.sv -----
`timescale 1ns / 1ps
package pai_pkg;

  localparam int unsigned NumObj   = 4;
  localparam int unsigned TagW     = 32;
  localparam int unsigned CfgW     = 3;
  localparam int unsigned StatusW  = 3;
  localparam logic [CfgW-1:0] CfgReset = 3'd2;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED     = 3'd0,
    ST_DOMINATED = 3'd1,
    ST_EQUAL     = 3'd2,
    ST_FULL      = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_READ_OOR  = 3'd5
  } pai_status_e;

  typedef enum logic [1:0] {
    REL_NONDOM    = 2'd0,
    REL_DOMINATES = 2'd1,
    REL_DOMINATED = 2'd2,
    REL_EQUAL     = 2'd3
  } pai_rel_e;

endpackage

// ----- rtl/core/pai_in_if.sv -----
`timescale 1ns / 1ps
interface pai_in_if #(
  parameter int unsigned OW = 32,
  parameter int unsigned IW = 6
);
  logic          valid;
  logic          ready;
  logic          kind;
  logic [OW-1:0] objective_0;
  logic [OW-1:0] objective_1;
  logic [OW-1:0] objective_2;
  logic [OW-1:0] objective_3;
  logic [31:0]   solution_tag;
  logic [IW-1:0] read_index;

  modport source (output valid, kind, objective_0, objective_1, objective_2, objective_3,
                  solution_tag, read_index, input ready);
  modport sink (input valid, kind, objective_0, objective_1, objective_2, objective_3,
                solution_tag, read_index, output ready);
endinterface

interface pai_out_if #(
  parameter int unsigned OW = 32,
  parameter int unsigned CW = 7
);
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [CW-1:0] removed_count;
  logic [CW-1:0] archive_size;
  logic [OW-1:0] read_objective_0;
  logic [OW-1:0] read_objective_1;
  logic [OW-1:0] read_objective_2;
  logic [OW-1:0] read_objective_3;
  logic [31:0]   read_tag;

  modport source (output valid, status, removed_count, archive_size, read_objective_0,
                  read_objective_1, read_objective_2, read_objective_3, read_tag,
                  input ready);
  modport sink (input valid, status, removed_count, archive_size, read_objective_0,
                read_objective_1, read_objective_2, read_objective_3, read_tag,
                output ready);
endinterface

// ----- rtl/core/pai_cell.sv -----
`timescale 1ns / 1ps
module pai_cell #(
  parameter int unsigned DW = 160
) (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic          load_i,
  input  logic [DW-1:0] load_data_i,
  input  logic [DW-1:0] next_data_i,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= next_data_i;
    end
  end

  assign data_o = data_q;

endmodule

// ----- rtl/core/pareto_archive_insert_core.sv -----
`timescale 1ns / 1ps
// pareto archive insert core
// keeps a bounded pareto archive (all objectives minimized) in a chain of cells
// in_i: insert (kind 0) or read (kind 1) transactions, valid/ready
// out_o: exactly one result transaction per input transaction, valid/ready
// cfg_we_i/cfg_wdata_i: objectives compared per solution, write only when idle
// an insert pops every stored entry from the head of the chain once, compares
// it with the candidate and pushes survivors back at the tail, one entry per
// cycle; the scan is followed by one append step and then the output load,
// while a read goes straight to the output load; the input is ready again as
// soon as the result is loaded into the output register
// a new transaction is accepted once the previous one has moved to the output
// register, so work goes on while a finished result waits there
// if the receiver stalls with a result held and another one finished, the
// core waits in its final state until the output register frees up
// reset empties the archive and sets the objective count to 2; the cells
// themselves are not cleared
module pareto_archive_insert_core #(
  parameter int unsigned ARCHIVE_DEPTH   = 64,
  parameter int unsigned OBJECTIVE_WIDTH = 32,
  localparam int unsigned IW = $clog2(ARCHIVE_DEPTH),
  localparam int unsigned CW = $clog2(ARCHIVE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [pai_pkg::CfgW-1:0] cfg_wdata_i,
  pai_in_if.sink                in_i,
  pai_out_if.source             out_o
);
  import pai_pkg::*;

  localparam int unsigned OW = OBJECTIVE_WIDTH;
  localparam int unsigned DW = NumObj * OW + TagW;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPEND, S_FIN} state_e;

  state_e state_q;
  logic [CfgW-1:0] cfg_q;
  logic [CW-1:0] fill_q, rem_q, removed_q;
  logic stop_q;
  logic [NumObj-1:0][OW-1:0] cand_q;
  logic [TagW-1:0] tag_q;
  logic [CfgW-1:0] nobj_q;

  logic [StatusW-1:0] pend_status_q;
  logic [CW-1:0] pend_size_q, pend_removed_q;
  logic [DW-1:0] pend_data_q;

  logic out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [CW-1:0] out_size_q, out_removed_q;
  logic [DW-1:0] out_data_q;

  logic [DW-1:0] cell_data [ARCHIVE_DEPTH];
  logic shift;
  logic load_en;
  logic [IW-1:0] load_idx;
  logic [DW-1:0] load_data;

  logic accept;
  logic cand_better, entry_better;
  pai_rel_e rel;
  logic keep;
  logic [CfgW-1:0] nobj_sat;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign nobj_sat = (cfg_q > CfgW'(NumObj)) ? CfgW'(NumObj) : cfg_q;

  always_comb begin
    cand_better  = 1'b0;
    entry_better = 1'b0;
    for (int k = 0; k < NumObj; k++) begin
      if (CfgW'(k) < nobj_q) begin
        if ($signed(cand_q[k]) < $signed(cell_data[0][TagW + k*OW +: OW])) begin
          cand_better = 1'b1;
        end else if ($signed(cell_data[0][TagW + k*OW +: OW]) < $signed(cand_q[k])) begin
          entry_better = 1'b1;
        end
      end
    end
    if (!cand_better && !entry_better) rel = REL_EQUAL;
    else if (cand_better && !entry_better) rel = REL_DOMINATES;
    else if (entry_better && !cand_better) rel = REL_DOMINATED;
    else rel = REL_NONDOM;
  end

  assign keep = stop_q || (rel != REL_DOMINATES);

  always_comb begin
    shift     = 1'b0;
    load_en   = 1'b0;
    load_idx  = IW'(fill_q - CW'(1));
    load_data = cell_data[0];
    case (state_q)
      S_SCAN: begin
        shift   = 1'b1;
        load_en = keep;
      end
      S_APPEND: begin
        load_idx  = IW'(fill_q);
        load_data = {cand_q, tag_q};
        load_en   = !stop_q && (fill_q != CW'(ARCHIVE_DEPTH));
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < ARCHIVE_DEPTH; g++) begin : g_cell
    logic [DW-1:0] next_data;
    if (g == ARCHIVE_DEPTH - 1) begin : g_last
      assign next_data = cell_data[g];
    end else begin : g_mid
      assign next_data = cell_data[g+1];
    end
    pai_cell #(.DW(DW)) u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift),
      .load_i      (load_en && (load_idx == IW'(g))),
      .load_data_i (load_data),
      .next_data_i (next_data),
      .data_o      (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CfgReset;
      fill_q      <= '0;
      stop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (out_valid_q && out_o.ready && (state_q != S_FIN)) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            cand_q    <= {in_i.objective_3, in_i.objective_2,
                          in_i.objective_1, in_i.objective_0};
            tag_q     <= in_i.solution_tag;
            nobj_q    <= nobj_sat;
            rem_q     <= fill_q;
            removed_q <= '0;
            stop_q    <= 1'b0;
            if (in_i.kind) begin
              pend_size_q    <= fill_q;
              pend_removed_q <= '0;
              if (CW'(in_i.read_index) < fill_q) begin
                pend_status_q <= ST_READ_OK;
                pend_data_q   <= cell_data[in_i.read_index];
              end else begin
                pend_status_q <= ST_READ_OOR;
                pend_data_q   <= '0;
              end
              state_q <= S_FIN;
            end else if (fill_q == '0) begin
              state_q <= S_APPEND;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!keep) begin
            fill_q    <= fill_q - CW'(1);
            removed_q <= removed_q + CW'(1);
          end
          if (!stop_q && rel == REL_DOMINATED) begin
            stop_q        <= 1'b1;
            pend_status_q <= ST_DOMINATED;
          end else if (!stop_q && rel == REL_EQUAL) begin
            stop_q        <= 1'b1;
            pend_status_q <= ST_EQUAL;
          end
          rem_q <= rem_q - CW'(1);
          if (rem_q == CW'(1)) state_q <= S_APPEND;
        end
        S_APPEND: begin
          pend_removed_q <= removed_q;
          pend_data_q    <= '0;
          if (stop_q) begin
            pend_size_q <= fill_q;
          end else if (fill_q == CW'(ARCHIVE_DEPTH)) begin
            pend_status_q <= ST_FULL;
            pend_size_q   <= fill_q;
          end else begin
            pend_status_q <= ST_ADDED;
            pend_size_q   <= fill_q + CW'(1);
            fill_q        <= fill_q + CW'(1);
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= pend_status_q;
            out_size_q    <= pend_size_q;
            out_removed_q <= pend_removed_q;
            out_data_q    <= pend_data_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_status_q;
  assign out_o.removed_count    = out_removed_q;
  assign out_o.archive_size     = out_size_q;
  assign out_o.read_tag         = out_data_q[TagW-1:0];
  assign out_o.read_objective_0 = out_data_q[TagW + 0*OW +: OW];
  assign out_o.read_objective_1 = out_data_q[TagW + 1*OW +: OW];
  assign out_o.read_objective_2 = out_data_q[TagW + 2*OW +: OW];
  assign out_o.read_objective_3 = out_data_q[TagW + 3*OW +: OW];

endmodule

// ----- rtl/core/pai_chk.sv -----
`timescale 1ns / 1ps
module pai_chk #(
  parameter int unsigned ARCHIVE_DEPTH = 64,
  parameter int unsigned CW = 7
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid,
  input logic          out_ready,
  input logic [2:0]    status,
  input logic [CW-1:0] removed_count,
  input logic [CW-1:0] archive_size,
  input logic [31:0]   read_tag
);
  import pai_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> archive_size <= CW'(ARCHIVE_DEPTH))
    else $error("archive size beyond depth");

  a_read_rm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status == ST_READ_OK || status == ST_READ_OOR) |-> removed_count == '0)
    else $error("read reports removals");

  a_added: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == ST_ADDED |-> archive_size != '0)
    else $error("added but archive empty");

  a_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == ST_READ_OOR |-> read_tag == '0)
    else $error("out of range read returns data");

endmodule

bind pareto_archive_insert_core pai_chk #(
  .ARCHIVE_DEPTH (ARCHIVE_DEPTH),
  .CW            (CW)
) u_pai_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .status        (out_o.status),
  .removed_count (out_o.removed_count),
  .archive_size  (out_o.archive_size),
  .read_tag      (out_o.read_tag)
);
